// ===== design/numeric_token_encoder_defines.svh =====
// Assertion macros for the numeric token encoder.
// Included by the top level; needs nothing else.
`ifndef NUMERIC_TOKEN_ENCODER_DEFINES_SVH
`define NUMERIC_TOKEN_ENCODER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define NTE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("numeric_token_encoder: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define NTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("numeric_token_encoder: next-cycle check failed");

`endif

// ===== design/nte_pkg.sv =====
// Types and constants for the numeric token encoder.
// Used by the top level and the testbench.
`default_nettype none

package nte_pkg;

    localparam int unsigned DIGIT_W = 54;
    localparam int unsigned CNT_W   = 5;

    localparam logic [CNT_W-1:0] CNT_MAX     = 5'd31;
    localparam logic [CNT_W-1:0] DEC_LEN_POS = 5'd17;  // 16 digits and the point
    localparam logic [CNT_W-1:0] DEC_LEN_NEG = 5'd18;  // plus the sign

    localparam logic [62:0] DRB_RESET  = 63'h4000_0000_0000_0000;
    localparam logic [63:0] TWO_POW_63 = 64'h8000_0000_0000_0000;
    // Largest magnitude whose tenfold does not exceed 2^63; a digit on anything larger overflows.
    localparam logic [63:0] MAG_LIMIT  = 64'd922337203685477580;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        KIND_INT  = 2'd0,
        KIND_DEC  = 2'd1,
        KIND_DICT = 2'd2
    } kind_t;

    typedef struct packed {
        logic [CNT_W-1:0]   char_count;
        logic               negative_seen;
        logic               leading_zero;
        logic               int_still_valid;
        logic [63:0]        int_magnitude;
        logic               int_overflowed;
        logic               dec_still_valid;
        logic [CNT_W-1:0]   dec_digit_count;
        logic               point_seen;
        logic [CNT_W-1:0]   point_index_left;
        logic [DIGIT_W-1:0] dec_digits;
    } tok_state_t;

    localparam tok_state_t TOK_CLEAR = '{
        char_count:       '0,
        negative_seen:    1'b0,
        leading_zero:     1'b0,
        int_still_valid:  1'b1,
        int_magnitude:    '0,
        int_overflowed:   1'b0,
        dec_still_valid:  1'b1,
        dec_digit_count:  '0,
        point_seen:       1'b0,
        point_index_left: '0,
        dec_digits:       '0
    };

endpackage

`default_nettype wire

// ===== design/nte_ifs.sv =====
// Valid/ready channel interfaces for the numeric token encoder.
// Character beats in, classified results out; no dependencies.
`default_nettype none

interface nte_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       empty_token;
    logic       last_char;

    modport source (output valid, char_code, empty_token, last_char, input ready);
    modport sink   (input valid, char_code, empty_token, last_char, output ready);
endinterface

interface nte_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  token_kind;
    logic signed [63:0] encoded_value;

    modport source (output valid, token_kind, encoded_value, input ready);
    modport sink   (input valid, token_kind, encoded_value, output ready);
endinterface

`default_nettype wire

// ===== design/numeric_token_encoder.sv =====
// Numeric token encoder: one character beat per cycle, one result per token.
// Latency: the result beat is valid the cycle after the beat that ends the token.
// Throughput: one character beat every cycle; the result register frees itself
// in the same cycle it is taken, so a stalled result only holds input off.
// Reset (rst_n, async, active low) clears the token state and the result valid,
// and sets dict_range_begin to 2^62.
`default_nettype none
`include "numeric_token_encoder_defines.svh"

module numeric_token_encoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [62:0] cfg_wr_data,
    nte_char_if.sink         chars,
    nte_result_if.source     results
);

    nte_pkg::tok_state_t tok_reg, tok_next, upd;
    logic [62:0] drb_reg;

    logic        res_valid_reg, res_valid_next;
    logic [1:0]  res_kind_reg, res_kind_next;
    logic [63:0] res_value_reg, res_value_next;

    logic        accept, ends;
    logic        is_digit;
    logic [3:0]  digit;
    logic [63:0] mag_step;
    logic [nte_pkg::DIGIT_W-1:0] dec_step;

    logic        int_ok, dec_ok, range_ok;
    logic [63:0] int_val;
    logic [nte_pkg::CNT_W-1:0] max_len, right, dcount_m1, right_m1;

    assign chars.ready = !res_valid_reg || results.ready;
    assign accept      = chars.valid && chars.ready;
    assign ends        = chars.empty_token || chars.last_char;

    assign is_digit = (chars.char_code >= nte_pkg::CH_ZERO) &&
                      (chars.char_code <= nte_pkg::CH_NINE);
    assign digit    = chars.char_code[3:0];

    // x*10 + d as two shifted adds
    assign mag_step = {tok_reg.int_magnitude[60:0], 3'b000} +
                      {tok_reg.int_magnitude[62:0], 1'b0} + {60'd0, digit};
    assign dec_step = {tok_reg.dec_digits[nte_pkg::DIGIT_W-4:0], 3'b000} +
                      {tok_reg.dec_digits[nte_pkg::DIGIT_W-2:0], 1'b0} +
                      {{(nte_pkg::DIGIT_W-4){1'b0}}, digit};

    // token state after this beat's character
    always_comb
    begin
        upd = tok_reg;
        if (!chars.empty_token)
        begin
            if (tok_reg.char_count == '0 && chars.char_code == nte_pkg::CH_MINUS)
            begin
                upd.negative_seen = 1'b1;
            end
            else if (is_digit)
            begin
                if (tok_reg.leading_zero)
                begin
                    upd.int_still_valid = 1'b0;
                end
                if (tok_reg.negative_seen && tok_reg.char_count == 5'd1 && digit == 4'd0)
                begin
                    upd.int_still_valid = 1'b0;
                end
                if (!tok_reg.negative_seen && tok_reg.char_count == '0 && digit == 4'd0)
                begin
                    upd.leading_zero = 1'b1;
                end
                if (!tok_reg.int_overflowed)
                begin
                    if (tok_reg.int_magnitude > nte_pkg::MAG_LIMIT ||
                        mag_step > nte_pkg::TWO_POW_63)
                    begin
                        upd.int_overflowed = 1'b1;
                    end
                    else
                    begin
                        upd.int_magnitude = mag_step;
                    end
                end
                upd.dec_digits = dec_step;
                if (tok_reg.dec_digit_count != nte_pkg::CNT_MAX)
                begin
                    upd.dec_digit_count = tok_reg.dec_digit_count + 5'd1;
                end
            end
            else if (chars.char_code == nte_pkg::CH_POINT && !tok_reg.point_seen)
            begin
                upd.point_seen       = 1'b1;
                upd.point_index_left = tok_reg.char_count;
                upd.int_still_valid  = 1'b0;
            end
            else
            begin
                upd.int_still_valid = 1'b0;
                upd.dec_still_valid = 1'b0;
            end
            if (tok_reg.char_count != nte_pkg::CNT_MAX)
            begin
                upd.char_count = tok_reg.char_count + 5'd1;
            end
        end
    end

    // classification of the finished token
    always_comb
    begin
        if (upd.negative_seen)
        begin
            range_ok = upd.int_magnitude <= nte_pkg::TWO_POW_63;
            max_len  = nte_pkg::DEC_LEN_NEG;
            int_val  = 64'd0 - upd.int_magnitude;
        end
        else
        begin
            range_ok = upd.int_magnitude < {1'b0, drb_reg};
            max_len  = nte_pkg::DEC_LEN_POS;
            int_val  = upd.int_magnitude;
        end
        right     = upd.char_count - 5'd1 - upd.point_index_left;
        dcount_m1 = upd.dec_digit_count - 5'd1;
        right_m1  = right - 5'd1;

        int_ok = upd.int_still_valid && !upd.int_overflowed &&
                 upd.dec_digit_count != '0 && upd.char_count != '0 && range_ok;
        dec_ok = upd.char_count != '0 && upd.dec_still_valid && upd.point_seen &&
                 upd.dec_digit_count != '0 && upd.char_count <= max_len && right != '0;

        if (int_ok)
        begin
            res_kind_next  = nte_pkg::KIND_INT;
            res_value_next = int_val;
        end
        else if (dec_ok)
        begin
            res_kind_next  = nte_pkg::KIND_DEC;
            res_value_next = {upd.negative_seen, dcount_m1[3:0], right_m1[3:0], 1'b0,
                              upd.dec_digits};
        end
        else
        begin
            res_kind_next  = nte_pkg::KIND_DICT;
            res_value_next = '0;
        end
    end

    always_comb
    begin
        tok_next       = tok_reg;
        res_valid_next = res_valid_reg && !results.ready;
        if (accept)
        begin
            tok_next = ends ? nte_pkg::TOK_CLEAR : upd;
            if (ends)
            begin
                res_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg       <= nte_pkg::TOK_CLEAR;
            drb_reg       <= nte_pkg::DRB_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            tok_reg       <= tok_next;
            res_valid_reg <= res_valid_next;
            if (cfg_wr_en)
            begin
                drb_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && ends)
        begin
            res_kind_reg  <= res_kind_next;
            res_value_reg <= res_value_next;
        end
    end

    assign results.valid         = res_valid_reg;
    assign results.token_kind    = res_kind_reg;
    assign results.encoded_value = res_value_reg;

    `NTE_ASSERT_NEXT(a_end_gives_result, clk, rst_n, accept && ends, results.valid)
    `NTE_ASSERT_NEXT(a_mid_no_result, clk, rst_n,
        accept && !ends && (!results.valid || results.ready), !results.valid)
    `NTE_ASSERT_SAME(a_dict_zero, clk, rst_n,
        results.valid && results.token_kind == nte_pkg::KIND_DICT,
        results.encoded_value == '0)
    `NTE_ASSERT_SAME(a_mag_bound, clk, rst_n, 1'b1,
        tok_reg.int_magnitude <= nte_pkg::TWO_POW_63)

endmodule

`default_nettype wire

// ===== sim/tb_numeric_token_encoder.sv =====
// Self-checking testbench for numeric_token_encoder: random and directed tokens,
// each result checked against an in-bench classifier.
// Needs nte_pkg, the channel interfaces in nte_ifs.sv and the encoder RTL.

module tb_numeric_token_encoder;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned MAX_REPORTS = 10;

    typedef logic [7:0] char_q_t [$];

    typedef struct {
        nte_pkg::kind_t kind;
        logic [63:0]    value;
    } token_result_t;

    // Mirrors the token classifier and keeps the results still owed by the block.
    class token_scoreboard;
        logic [62:0]   range_floor;
        logic [4:0]    n_chars;
        bit            neg;
        bit            lead_zero;
        bit            int_ok;
        logic [63:0]   mag;
        bit            mag_ovf;
        bit            dec_ok;
        logic [4:0]    n_digits;
        bit            point;
        logic [4:0]    point_at;
        logic [53:0]   digits;
        token_result_t pending[$];
        int unsigned   errors;
        int unsigned   tokens_checked;
        int unsigned   kind_seen[3];

        function new();
            range_floor = nte_pkg::DRB_RESET;
            errors = 0;
            tokens_checked = 0;
            kind_seen = '{0, 0, 0};
            clear_token();
        endfunction

        function void clear_token();
            n_chars   = '0;
            neg       = 1'b0;
            lead_zero = 1'b0;
            int_ok    = 1'b1;
            mag       = '0;
            mag_ovf   = 1'b0;
            dec_ok    = 1'b1;
            n_digits  = '0;
            point     = 1'b0;
            point_at  = '0;
            digits    = '0;
        endfunction

        function void absorb_char(logic [7:0] c);
            logic [3:0]  d;
            logic [63:0] next_mag;
            if (n_chars == 0 && c == nte_pkg::CH_MINUS)
            begin
                neg = 1'b1;
            end
            else if (c >= nte_pkg::CH_ZERO && c <= nte_pkg::CH_NINE)
            begin
                d = c[3:0];
                if (lead_zero)
                    int_ok = 1'b0;
                // "-0..." is never canonical
                if (neg && n_chars == 1 && d == 0)
                    int_ok = 1'b0;
                if (!neg && n_chars == 0 && d == 0)
                    lead_zero = 1'b1;
                if (!mag_ovf)
                begin
                    if (mag > nte_pkg::MAG_LIMIT)
                        mag_ovf = 1'b1;
                    else
                    begin
                        next_mag = mag * 64'd10 + 64'(d);
                        if (next_mag > nte_pkg::TWO_POW_63)
                            mag_ovf = 1'b1;
                        else
                            mag = next_mag;
                    end
                end
                digits = digits * 54'd10 + 54'(d);
                if (n_digits != nte_pkg::CNT_MAX)
                    n_digits = n_digits + 5'd1;
            end
            else if (c == nte_pkg::CH_POINT && !point)
            begin
                point    = 1'b1;
                point_at = n_chars;
                int_ok   = 1'b0;
            end
            else
            begin
                int_ok = 1'b0;
                dec_ok = 1'b0;
            end
            if (n_chars != nte_pkg::CNT_MAX)
                n_chars = n_chars + 5'd1;
        endfunction

        function token_result_t classify();
            token_result_t r;
            bit            int_hit;
            int            right;
            logic [4:0]    max_len;
            r.kind  = nte_pkg::KIND_DICT;
            r.value = '0;
            int_hit = int_ok && !mag_ovf && n_digits != 0;
            if (int_hit)
                int_hit = neg ? (mag <= nte_pkg::TWO_POW_63) : (mag < {1'b0, range_floor});
            if (n_chars == 0)
                int_hit = 1'b0;
            if (int_hit)
            begin
                r.kind  = nte_pkg::KIND_INT;
                r.value = neg ? 64'd0 - mag : mag;
            end
            else if (n_chars != 0 && dec_ok && point && n_digits != 0)
            begin
                max_len = neg ? nte_pkg::DEC_LEN_NEG : nte_pkg::DEC_LEN_POS;
                if (n_chars <= max_len)
                begin
                    right = int'(n_chars) - 1 - int'(point_at);
                    if (right != 0)
                    begin
                        r.kind  = nte_pkg::KIND_DEC;
                        r.value = {neg, 4'(n_digits - 5'd1), 4'(right - 1), 1'b0, digits};
                    end
                end
            end
            return r;
        endfunction

        function void note_beat(logic [7:0] c, logic is_mark, logic is_last);
            if (!is_mark)
            begin
                absorb_char(c);
                if (!is_last)
                    return;
            end
            pending.insert(pending.size(), classify());
            clear_token();
        endfunction

        function void flag(string what);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("ERROR: %s", what);
        endfunction

        function void check_result(logic [1:0] kind, logic [63:0] value);
            token_result_t want;
            if (pending.size() == 0)
            begin
                flag($sformatf("result kind %0d value %h with no token pending", kind, value));
                return;
            end
            want = pending.pop_front();
            tokens_checked++;
            if (kind !== want.kind)
                flag($sformatf("token %0d: token_kind expected %0d, got %0d",
                               tokens_checked, want.kind, kind));
            else if (value !== want.value)
                flag($sformatf("token %0d: encoded_value expected %h, got %h",
                               tokens_checked, want.value, value));
            else
                kind_seen[kind]++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [62:0] cfg_wr_data;

    nte_char_if   char_ch();
    nte_result_if result_ch();

    numeric_token_encoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .chars       (char_ch),
        .results     (result_ch)
    );

    token_scoreboard sb = new();

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned beats_sent;
    int unsigned range_writes;
    int unsigned hold_len;
    int unsigned holds_asked;
    int unsigned holds_done;
    int unsigned cycle_count;

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Beat monitors: both sample pre-edge values at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && char_ch.valid && char_ch.ready)
            sb.note_beat(char_ch.char_code, char_ch.empty_token, char_ch.last_char);
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check_result(result_ch.token_kind, result_ch.encoded_value);
    end

    // Result receiver, with a counted hold-off on request.
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_done != holds_asked)
            begin
                hold_left  = hold_len;
                holds_done = holds_asked;
            end
            if (hold_left != 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, sb.pending.size());
        $display("tb_numeric_token_encoder NOT OK");
        $finish;
    end

    task automatic send_beat(input logic [7:0] c, input logic is_mark, input logic is_last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            char_ch.valid <= 1'b0;
            @(posedge clk);
        end
        char_ch.valid       <= 1'b1;
        char_ch.char_code   <= c;
        char_ch.empty_token <= is_mark;
        char_ch.last_char   <= is_last;
        do
            @(posedge clk);
        while (!char_ch.ready);
        beats_sent++;
    endtask

    // An empty queue always ends with an empty-token mark.
    task automatic send_token(input char_q_t s, input bit close_by_mark);
        for (int i = 0; i < s.size(); i++)
            send_beat(s[i], 1'b0, (i == s.size() - 1) && !close_by_mark);
        if (close_by_mark || s.size() == 0)
            send_beat(8'($urandom), 1'b1, 1'($urandom));
    endtask

    task automatic drain();
        char_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        // result valid rises the cycle after the closing beat
        repeat (3) @(posedge clk);
    endtask

    task automatic write_range(input logic [62:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.range_floor = v;
        range_writes++;
    endtask

    task automatic hold_receiver(input int unsigned cycles);
        hold_len = cycles;
        holds_asked++;
    endtask

    function automatic char_q_t text_q(string s);
        char_q_t q;
        for (int i = 0; i < s.len(); i++)
            q.insert(q.size(), s[i]);
        return q;
    endfunction

    function automatic char_q_t int_text(bit neg, logic [63:0] mag);
        char_q_t q;
        q = text_q($sformatf("%0d", mag));
        if (neg)
            q.push_front(nte_pkg::CH_MINUS);
        return q;
    endfunction

    function automatic char_q_t random_token();
        char_q_t     q;
        int unsigned pick;
        int unsigned n;
        int unsigned p;
        bit          neg;
        logic [63:0] mag;
        string       alpha;
        alpha = "-.0123456789x";
        pick  = $urandom_range(99);
        neg   = $urandom_range(1);
        if (pick < 35)
        begin
            mag = {$urandom, $urandom} >> $urandom_range(63);
            q = int_text(neg, mag);
            // zero padding now and then
            if ($urandom_range(9) == 0)
                q.insert(neg ? 1 : 0, nte_pkg::CH_ZERO);
        end
        else if (pick < 45)
        begin
            case ($urandom_range(5))
                0: mag = nte_pkg::TWO_POW_63 - 64'd1;
                1: mag = nte_pkg::TWO_POW_63;
                2: mag = nte_pkg::TWO_POW_63 + 64'd1;
                3: mag = {1'b0, sb.range_floor} - 64'd1;
                4: mag = {1'b0, sb.range_floor};
                default: mag = {1'b0, sb.range_floor} + 64'd1;
            endcase
            q = int_text(neg, mag);
        end
        else if (pick < 80)
        begin
            n = ($urandom_range(99) < 85) ? $urandom_range(1, 16) : $urandom_range(17, 20);
            p = $urandom_range(n);
            if (neg)
                q.insert(q.size(), nte_pkg::CH_MINUS);
            for (int i = 0; i < n; i++)
            begin
                if (i == p)
                    q.insert(q.size(), nte_pkg::CH_POINT);
                q.insert(q.size(), nte_pkg::CH_ZERO + 8'($urandom_range(9)));
            end
            if (p == n)
                q.insert(q.size(), nte_pkg::CH_POINT);
            if ($urandom_range(9) == 0)
                q.insert($urandom_range(q.size()),
                         $urandom_range(1) ? nte_pkg::CH_POINT
                                           : 8'($urandom_range(8'h41, 8'h7A)));
        end
        else if (pick < 90)
        begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
                q.insert(q.size(), alpha[$urandom_range(alpha.len() - 1)]);
        end
        else if (pick < 96)
        begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                q.insert(q.size(), 8'($urandom_range(255)));
        end
        else
        begin
            // long runs of digits; the longer ones saturate the counters
            n = $urandom_range(25, 40);
            for (int i = 0; i < n; i++)
                q.insert(q.size(), nte_pkg::CH_ZERO + 8'($urandom_range(9)));
            if ($urandom_range(1))
                q.insert($urandom_range(n), nte_pkg::CH_POINT);
        end
        return q;
    endfunction

    task automatic run_random(input int unsigned beat_goal);
        int unsigned start;
        char_q_t     none;
        start = beats_sent;
        while (beats_sent - start < beat_goal)
        begin
            if ($urandom_range(99) < 3)
                send_token(none, 1'b1);
            else
                send_token(random_token(), $urandom_range(99) < 10);
        end
    endtask

    initial
    begin
        char_q_t none;
        char_q_t ff_tok;
        send_idle_pct  = 6;
        recv_stall_pct = 75;
        beats_sent     = 0;
        range_writes   = 0;
        hold_len       = 0;
        holds_asked    = 0;
        holds_done     = 0;
        cycle_count    = 0;
        rst_n               <= 1'b0;
        cfg_wr_en           <= 1'b0;
        cfg_wr_data         <= '0;
        char_ch.valid       <= 1'b0;
        char_ch.char_code   <= '0;
        char_ch.empty_token <= 1'b0;
        char_ch.last_char   <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty token, zero forms, lone sign, padding, decimals, junk, token closed by a mark
        ff_tok.insert(0, 8'hFF);
        send_token(none, 1'b1);
        send_token(text_q("0"), 1'b0);
        send_token(text_q("-0"), 1'b0);
        send_token(text_q("-"), 1'b0);
        send_token(text_q("07"), 1'b0);
        send_token(text_q("1.5"), 1'b0);
        send_token(text_q("-.5"), 1'b0);
        send_token(text_q("5."), 1'b0);
        send_token(ff_tok, 1'b0);
        send_token(text_q("7"), 1'b1);

        run_random(300);
        drain();

        write_range(63'h7FFF_FFFF_FFFF_FFFF);
        send_idle_pct  = 75;
        recv_stall_pct = 6;
        run_random(150);
        hold_receiver(250);
        run_random(150);
        drain();

        write_range('0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(80);
        drain();

        write_range(63'($urandom_range(1, 1000000)));
        hold_receiver(300);
        run_random(250);
        drain();
        repeat (8) @(posedge clk);

        if (sb.pending.size() != 0)
            sb.flag($sformatf("%0d results never arrived", sb.pending.size()));
        $display("sent %0d beats over %0d range settings; checked %0d tokens",
                 beats_sent, range_writes + 1, sb.tokens_checked);
        $display("  %0d integers, %0d packed decimals, %0d dictionary tokens, %0d errors",
                 sb.kind_seen[nte_pkg::KIND_INT], sb.kind_seen[nte_pkg::KIND_DEC],
                 sb.kind_seen[nte_pkg::KIND_DICT], sb.errors);
        if (sb.errors == 0)
            $display("tb_numeric_token_encoder OK");
        else
            $display("tb_numeric_token_encoder NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/nte_pkg.sv
design/nte_ifs.sv
design/numeric_token_encoder.sv
sim/tb_numeric_token_encoder.sv
